/* design/hbd_pkg.sv */
// shared types, constants and coefficient table for the half-band decimator cascade
package hbd_pkg;

  // fixed data formats
  localparam int SampleBits = 16;
  localparam int CoefBits   = 18;
  localparam int CoefFrac   = CoefBits - 1;
  localparam int Taps       = 39;
  localparam int HalfTaps   = 20;
  localparam int NumOctaves = 8;
  localparam int OctBits    = 3;
  localparam int ActBits    = 4;
  localparam int TapBits    = 6;

  // reset value of the active octave count
  localparam logic [ActBits-1:0] ActiveReset = 4'd8;

  // register map: index taken from paddr bit 2
  localparam logic RegPhaseMask  = 1'b0;
  localparam logic RegActiveOcts = 1'b1;

  // first half and centre tap of the symmetric low-pass, Q1.17
  localparam logic signed [CoefBits-1:0] HalfCoef [HalfTaps] = '{
    18'sd45, 18'sd80, -18'sd112, -18'sd417, -18'sd168,
    18'sd602, 18'sd442, -18'sd983, -18'sd1055, 18'sd1388,
    18'sd2061, -18'sd1823, -18'sd3721, 18'sd2229, 18'sd6603,
    -18'sd2563, -18'sd12801, 18'sd2782, 18'sd41342, 18'sd62677
  };

  // input beat
  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         restart;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [OctBits-1:0]           octave;
    logic signed [SampleBits-1:0] value;
    logic                         last;
  } out_beat_t;

  // control from sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
    logic keep;
  } mac_ctrl_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MAC,
    ST_ROUND,
    ST_EMIT,
    ST_FLUSH
  } hbd_state_e;

  // coefficient for tap idx, mirrored about the centre tap
  function automatic logic signed [CoefBits-1:0] coef_at(input logic [TapBits-1:0] idx);
    int         j;
    logic [4:0] j5;
    j = int'(idx);
    if (j >= HalfTaps) j = Taps - 1 - j;
    if (j < 0 || j >= HalfTaps) j = HalfTaps - 1;
    j5 = 5'(j);
    return HalfCoef[j5];
  endfunction

endpackage

/* design/hbd_mac.sv */
// shared multiply-accumulate unit with rounding and saturation of the sum
module hbd_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  hbd_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [hbd_pkg::SampleBits-1:0] smp_i,
  input  logic signed [hbd_pkg::CoefBits-1:0]   coef_i,
  output logic signed [hbd_pkg::SampleBits-1:0] res_o
);
  import hbd_pkg::*;

  localparam int ProdW = SampleBits + CoefBits;
  localparam int AccW  = ProdW + 6;
  localparam int ShW   = AccW + 1 - CoefFrac;
  localparam logic signed [AccW:0]  RoundHalf = (AccW+1)'(64'sd1 <<< (CoefFrac - 1));
  localparam logic signed [ShW-1:0] SatHi = ShW'((64'sd1 <<< (SampleBits - 1)) - 64'sd1);
  localparam logic signed [ShW-1:0] SatLo = ShW'(-(64'sd1 <<< (SampleBits - 1)));

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW:0]    rnd;
  logic signed [ShW-1:0]   shf;

  // product valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.valid & ~ctrl_i.clear;
    end
  end

  // product register and accumulator
  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= ctrl_i.keep ? smp_i * coef_i : ProdW'(0);
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // round half up, drop fraction bits, saturate
  always_comb begin
    rnd = (AccW+1)'(acc_q) + RoundHalf;
    shf = rnd[AccW:CoefFrac];
    if (shf > SatHi) begin
      res_o = SatHi[SampleBits-1:0];
    end else if (shf < SatLo) begin
      res_o = SatLo[SampleBits-1:0];
    end else begin
      res_o = shf[SampleBits-1:0];
    end
  end

endmodule

/* design/halfband_decimator_cascade_unit.sv */
// top level: sequencer, delay line memory, register port and result register
// order: the octave 0 result is loaded into the result register when stage 1 reports its own
// result, else at the flush; each firing stage writes its line, walks the taps newest first and
// rounds, then emits if it reports a result, and any result stall holds it there
// a new input beat is not taken until every result of the last one has been loaded into the
// result register; in_ready_o high only between items; reset clears at once
module halfband_decimator_cascade_unit #(
  parameter int NUM_OCTAVES = hbd_pkg::NumOctaves
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hbd_pkg::in_beat_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hbd_pkg::out_beat_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import hbd_pkg::*;

  localparam int Stages = NUM_OCTAVES - 1;
  localparam int Depth  = Stages * Taps;
  localparam int AW     = $clog2(Depth);
  localparam int SW     = (Stages > 1) ? $clog2(Stages) : 1;
  localparam int TW     = TapBits;

  hbd_state_e state_q, state_d;

  // configuration
  logic [Stages-1:0]  pmask_q;
  logic [ActBits-1:0] act_q;

  // per-stage line state
  logic [TW-1:0] wptr_q [Stages];
  logic [TW-1:0] fill_q [Stages];
  logic [Stages-1:0] phase_q;

  // sequencer registers
  logic [SW-1:0] s_q;
  logic [TW-1:0] cnt_q;
  logic [TW-1:0] rp_q;
  logic [TW-1:0] fill_cur_q;
  logic          v1_q;
  logic          keep_q;
  logic signed [CoefBits-1:0]   coef_q;
  logic signed [SampleBits-1:0] cur_q;
  logic [OctBits-1:0]           pend_oct_q;
  logic signed [SampleBits-1:0] pend_val_q;
  logic          out_valid_q;
  out_beat_t     out_q;

  // memory
  logic [SampleBits-1:0] line_mem [Depth];
  logic [SampleBits-1:0] rd_q;
  logic [AW-1:0] base, wr_addr, rd_addr;

  // control
  logic accept, slot_free, fire, last_stage, mac_done, emit;
  logic mem_we, load_out, out_last, step_s;
  logic [TW-1:0] fill_nxt, wptr_nxt;
  logic [OctBits-1:0] cur_oct;
  mac_ctrl_t mac_ctrl;
  logic signed [SampleBits-1:0] mac_res;
  logic cfg_we;

  // shared status
  always_comb begin
    int act_eff;
    act_eff = int'(act_q);
    if (act_eff == 0) act_eff = 1;
    if (act_eff > NUM_OCTAVES) act_eff = NUM_OCTAVES;
    emit       = (int'(s_q) + 1) < act_eff;
    cur_oct    = OctBits'(int'(s_q) + 1);
    accept     = in_valid_i & in_ready_o;
    slot_free  = ~out_valid_q | out_ready_i;
    fire       = phase_q[s_q] == pmask_q[s_q];
    last_stage = s_q == SW'(Stages - 1);
    mac_done   = cnt_q == TW'(Taps + 1);
    fill_nxt   = (fill_q[s_q] == TW'(Taps)) ? TW'(Taps) : fill_q[s_q] + 1'b1;
    wptr_nxt   = (wptr_q[s_q] == TW'(Taps - 1)) ? '0 : wptr_q[s_q] + 1'b1;
    base       = AW'(int'(s_q) * Taps);
    wr_addr    = base + AW'(wptr_q[s_q]);
    rd_addr    = base + AW'(rp_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_WRITE;
      ST_WRITE: state_d = fire ? ST_MAC : ST_FLUSH;
      ST_MAC:   if (mac_done) state_d = ST_ROUND;
      ST_ROUND: begin
        if (emit) state_d = ST_EMIT;
        else      state_d = last_stage ? ST_FLUSH : ST_WRITE;
      end
      ST_EMIT:  if (slot_free) state_d = last_stage ? ST_FLUSH : ST_WRITE;
      ST_FLUSH: if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o     = 1'b0;
    mem_we         = 1'b0;
    load_out       = 1'b0;
    out_last       = 1'b0;
    step_s         = 1'b0;
    mac_ctrl.clear = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_WRITE: begin
        mem_we         = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      ST_ROUND: step_s = ~emit & ~last_stage;
      ST_EMIT: begin
        load_out = slot_free;
        step_s   = slot_free & ~last_stage;
      end
      ST_FLUSH: begin
        load_out = slot_free;
        out_last = 1'b1;
      end
      default: ;
    endcase
    mac_ctrl.valid = v1_q;
    mac_ctrl.keep  = keep_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pmask_q     <= '0;
      act_q       <= ActiveReset;
      phase_q     <= '0;
      s_q         <= '0;
      cnt_q       <= '0;
      rp_q        <= '0;
      fill_cur_q  <= '0;
      v1_q        <= 1'b0;
      keep_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Stages; i++) begin
        wptr_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // register writes
      if (cfg_we) begin
        case (paddr[2])
          RegPhaseMask:  pmask_q <= pwdata[Stages-1:0];
          RegActiveOcts: act_q   <= pwdata[ActBits-1:0];
          default: ;
        endcase
      end
      // restart empties every line
      if (accept) begin
        s_q <= '0;
        if (in_data_i.restart) begin
          phase_q <= '0;
          for (int i = 0; i < Stages; i++) fill_q[i] <= '0;
        end
      end
      // push sample into current stage line
      if (state_q == ST_WRITE) begin
        rp_q          <= wptr_q[s_q];
        wptr_q[s_q]   <= wptr_nxt;
        fill_q[s_q]   <= fill_nxt;
        fill_cur_q    <= fill_nxt;
        phase_q[s_q]  <= ~phase_q[s_q];
        cnt_q         <= '0;
      end
      // tap walk, newest first
      v1_q <= 1'b0;
      if (state_q == ST_MAC) begin
        cnt_q  <= cnt_q + 1'b1;
        rp_q   <= (rp_q == '0) ? TW'(Taps - 1) : rp_q - 1'b1;
        v1_q   <= cnt_q < TW'(Taps);
        keep_q <= cnt_q < fill_cur_q;
      end
      if (step_s) s_q <= s_q + 1'b1;
      // result register
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q      <= in_data_i.sample;
      pend_oct_q <= '0;
      pend_val_q <= in_data_i.sample;
    end
    if (state_q == ST_MAC) coef_q <= coef_at(cnt_q);
    if (state_q == ST_ROUND) cur_q <= mac_res;
    if (load_out) begin
      out_q.octave <= pend_oct_q;
      out_q.value  <= pend_val_q;
      out_q.last   <= out_last;
    end
    if (state_q == ST_EMIT && slot_free) begin
      pend_oct_q <= cur_oct;
      pend_val_q <= cur_q;
    end
  end

  // delay line memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[wr_addr] <= cur_q;
    rd_q <= line_mem[rd_addr];
  end

  hbd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .smp_i  (rd_q),
    .coef_i (coef_q),
    .res_o  (mac_res)
  );

  // register port
  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      RegPhaseMask:  prdata = 32'(pmask_q);
      RegActiveOcts: prdata = 32'(act_q);
      default:       prdata = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/hbd_checker.sv */
// port-level checks on the decimator cascade, bound to the top level
module hbd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input hbd_pkg::out_beat_t out_data_o,
  input logic               pready
);

  // a taken input beat keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready straight after an accepted beat");

  // an unfinished result sequence never coexists with input ready
  a_no_ready_mid_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input ready while a non-final result is pending");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind halfband_decimator_cascade_unit hbd_checker u_hbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

/* bench/halfband_decimator_cascade_unit_tb.sv */
// testbench for the half-band decimator cascade: random beats checked against a local predictor
module halfband_decimator_cascade_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hbd_pkg::*;

  // idle time after the last result so that silent stages finish
  localparam int SettleCycles = 400;
  localparam int RandomPerPhase = 36;
  localparam int NumPhases = 6;
  localparam int Stages = NumOctaves - 1;

  // first half and centre tap of the low-pass, Q1.17
  localparam int LowpassQ17 [HalfTaps] = '{
    45, 80, -112, -417, -168, 602, 442, -983, -1055, 1388,
    2061, -1823, -3721, 2229, 6603, -2563, -12801, 2782, 41342, 62677
  };

  // directed samples: full scale, zero, single bits and alternating patterns
  localparam logic [SampleBits-1:0] ProbeSamples [22] = '{
    16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h4000, 16'hc000, 16'h5555,
    16'haaaa, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h1234,
    16'hffff, 16'h7ffe, 16'h8001, 16'h0000, 16'h0100, 16'hfeff
  };

  // expected octave results, from a bit-exact copy of the cascade state
  class octave_ledger;
    logic signed [SampleBits-1:0] taps_line [Stages][Taps];
    bit                           phase_bit [Stages];
    logic [Stages-1:0]            fire_mask;
    logic [ActBits-1:0]           octave_count;
    out_beat_t                    pending [$];
    int                           faults;

    function new();
      clear_lines();
      fire_mask    = '0;
      octave_count = ActiveReset;
      faults       = 0;
    endfunction

    function void clear_lines();
      foreach (taps_line[s, i]) taps_line[s][i] = '0;
      foreach (phase_bit[s]) phase_bit[s] = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      case (idx)
        RegPhaseMask:  fire_mask = data[Stages-1:0];
        RegActiveOcts: octave_count = data[ActBits-1:0];
        default: ;
      endcase
    endfunction

    // symmetric 39-tap convolution, rounded half up and saturated
    function logic signed [SampleBits-1:0] lowpass(int st);
      longint acc;
      longint hi;
      int     j;
      acc = 0;
      hi  = (longint'(1) <<< (SampleBits - 1)) - 1;
      for (int i = 0; i < Taps; i++) begin
        j = (i < HalfTaps) ? i : Taps - 1 - i;
        acc += longint'(taps_line[st][i]) * longint'(LowpassQ17[j]);
      end
      acc = acc + (longint'(1) <<< (CoefFrac - 1));
      acc = acc >>> CoefFrac;
      if (acc > hi) acc = hi;
      if (acc < -hi - 1) acc = -hi - 1;
      return SampleBits'(acc);
    endfunction

    // one accepted input beat: push through the cascade and queue its results
    function void take_sample(in_beat_t b);
      logic signed [SampleBits-1:0] cur;
      out_beat_t                    batch [NumOctaves];
      int                           act;
      int                           n;
      bit                           p;
      cur = b.sample;
      if (b.restart) clear_lines();
      act = int'(octave_count);
      if (act == 0) act = 1;
      if (act > NumOctaves) act = NumOctaves;
      batch[0] = '{octave: '0, value: cur, last: 1'b0};
      n = 1;
      for (int st = 0; st < Stages; st++) begin
        for (int i = Taps - 1; i > 0; i--) taps_line[st][i] = taps_line[st][i-1];
        taps_line[st][0] = cur;
        p = phase_bit[st];
        phase_bit[st] = ~p;
        if (p != fire_mask[st]) break;
        cur = lowpass(st);
        if (st + 1 < act) begin
          batch[n] = '{octave: OctBits'(st + 1), value: cur, last: 1'b0};
          n++;
        end
      end
      batch[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) pending.push_back(batch[i]);
    endfunction

    // compare one result beat with the oldest expectation
    function void match_result(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result octave %0d value %0d last %0b",
                 $time, got.octave, got.value, got.last);
        faults++;
        return;
      end
      want = pending.pop_front();
      if (got.octave !== want.octave || got.value !== want.value ||
          got.last !== want.last) begin
        $display("%0t: result mismatch, expected octave %0d value %0d last %0b,",
                 $time, want.octave, want.value, want.last,
                 " got octave %0d value %0d last %0b",
                 got.octave, got.value, got.last);
        faults++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  octave_ledger ledger = new();
  int gap_pct   = 0;
  int stall_pct = 0;

  halfband_decimator_cascade_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  // result side: ready with random stall bursts
  always begin
    @(posedge clk_i);
    if (stall_pct == 0 || $urandom_range(0, 99) >= stall_pct) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      out_ready_i <= 1'b1;
    end
  end

  // check every result beat taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.match_result(out_data_o);
  end

  // register write: setup phase, access phase, then idle
  task automatic write_reg(logic idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ledger.write_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // one input beat, then maybe a gap
  task automatic push_sample(in_beat_t b);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.take_sample(b);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // wait for all results, then for silent stages to finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic in_beat_t random_item();
    in_beat_t b;
    case ($urandom_range(0, 15))
      0:       b.sample = 16'sh7fff;
      1:       b.sample = 16'sh8000;
      2:       b.sample = '0;
      3:       b.sample = '1;
      default: b.sample = SampleBits'($urandom);
    endcase
    b.restart = ($urandom_range(0, 149) == 0);
    return b;
  endfunction

  // restart, then near full scale samples matching the tap signs so stage 1 saturates
  task automatic drive_full_scale(bit negative);
    in_beat_t b;
    int       mag;
    int       j;
    b.restart = 1'b1;
    if (ledger.fire_mask[0]) begin
      b.sample = SampleBits'($urandom);
      push_sample(b);
      b.restart = 1'b0;
    end
    for (int i = 0; i < Taps; i++) begin
      j   = (i < HalfTaps) ? i : Taps - 1 - i;
      mag = $urandom_range(30000, 32767);
      b.sample = ((LowpassQ17[j] < 0) ^ negative) ? SampleBits'(-mag) : SampleBits'(mag);
      push_sample(b);
      b.restart = 1'b0;
    end
  endtask

  initial begin
    in_beat_t    b;
    logic [31:0] mask_word;
    logic [31:0] count_word;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats on reset settings: first beat fires every stage
    gap_pct   = 30;
    stall_pct = 30;
    foreach (ProbeSamples[i]) begin
      b.sample  = ProbeSamples[i];
      b.restart = (i == 0 || i == 15);
      push_sample(b);
    end
    settle();

    // phases with different register settings and idling
    for (int ph = 0; ph < NumPhases; ph++) begin
      mask_word  = $urandom & ~32'h7f;
      count_word = $urandom & ~32'hf;
      case (ph)
        0: begin mask_word |= 32'h7f; count_word |= 32'd8;  gap_pct = 25; stall_pct = 25; end
        1: begin                      count_word |= 32'd15; gap_pct = 0;  stall_pct = 40; end
        2: begin mask_word |= 32'h55;                       gap_pct = 40; stall_pct = 0;  end
        3: begin mask_word |= 32'h2a; count_word |= 32'd1;  gap_pct = 20; stall_pct = 20; end
        4: begin
          mask_word  |= $urandom_range(0, 127);
          count_word |= $urandom_range(2, 7);
          gap_pct = 30;
          stall_pct = 30;
        end
        default: begin
          mask_word  |= $urandom_range(0, 127);
          count_word |= $urandom_range(0, 15);
          gap_pct = 0;
          stall_pct = 0;
        end
      endcase
      write_reg(RegPhaseMask, mask_word);
      write_reg(RegActiveOcts, count_word);
      if (ph == 1) drive_full_scale(1'b0);
      if (ph == 3) drive_full_scale(1'b1);
      repeat (RandomPerPhase) push_sample(random_item());
      settle();
    end

    if (ledger.faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_500_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
design/hbd_pkg.sv
design/hbd_mac.sv
design/halfband_decimator_cascade_unit.sv
design/hbd_checker.sv
bench/halfband_decimator_cascade_unit_tb.sv
